>>> rtl/node_heartbeat_monitor_top_defines.svh
// ----------------------------------------------------------------------------
// Node heartbeat monitor - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef NODE_HEARTBEAT_MONITOR_TOP_DEFINES_SVH
`define NODE_HEARTBEAT_MONITOR_TOP_DEFINES_SVH

// same-cycle implication
`define NHM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NHM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/nhm_pkg.sv
// ----------------------------------------------------------------------------
// Node heartbeat monitor package
// Field widths, constants, action codes, sequencer states and store write bus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nhm_pkg;

    localparam int NODE_W  = 7;
    localparam int STATE_W = 7;
    localparam int TIME_W  = 32;
    localparam int ERR_W   = 8;
    localparam int CNT_W   = 32;
    localparam int ACT_W   = 3;

    localparam int NODE_COUNT_DEF = 127;

    localparam logic [TIME_W-1:0] DEFAULT_TIMEOUT = 32'd5000;
    localparam logic [ERR_W-1:0]  INVALID_ERROR   = 8'hFF;

    localparam logic [ACT_W-1:0] ACT_HEARTBEAT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_EMERGENCY = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SWEEP     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               hb_we;
        logic               em_we;
        logic [NODE_W-1:0]  addr;
        logic               online;
        logic [STATE_W-1:0] nmt;
        logic [TIME_W-1:0]  seen;
        logic [ERR_W-1:0]   err;
    } t_store_wr;

endpackage

>>> rtl/nhm_node_store.sv
// ----------------------------------------------------------------------------
// Node record store
// Heartbeat record (online, state, time) and error byte per node in
// synchronous RAMs, one read port with registered read data; never-written
// entries read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nhm_node_store
    import nhm_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [NODE_W-1:0]  i_rd_addr,
    input  t_store_wr          i_wr,
    output logic               o_rd_online,
    output logic [STATE_W-1:0] o_rd_nmt,
    output logic [TIME_W-1:0]  o_rd_seen,
    output logic [ERR_W-1:0]   o_rd_err
);

    localparam int HB_W = 1 + STATE_W + TIME_W;

    logic [HB_W-1:0]           r_hb_mem [0:NODE_COUNT];
    logic [ERR_W-1:0]          r_em_mem [0:NODE_COUNT];
    logic [NODE_COUNT:0]       r_hb_ok;
    logic [NODE_COUNT:0]       r_em_ok;
    logic [HB_W-1:0]           r_hb_q;
    logic [ERR_W-1:0]          r_em_q;
    logic                      r_hb_q_ok;
    logic                      r_em_q_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr.hb_we) begin
            r_hb_mem[i_wr.addr] <= {i_wr.online, i_wr.nmt, i_wr.seen};
        end
        r_hb_q <= r_hb_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.em_we) begin
            r_em_mem[i_wr.addr] <= i_wr.err;
        end
        r_em_q <= r_em_mem[i_rd_addr];
    end

    // written flags stand in for the zero reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_ok   <= '0;
            r_em_ok   <= '0;
            r_hb_q_ok <= 1'b0;
            r_em_q_ok <= 1'b0;
        end else begin
            if (i_wr.hb_we) begin
                r_hb_ok[i_wr.addr] <= 1'b1;
            end
            if (i_wr.em_we) begin
                r_em_ok[i_wr.addr] <= 1'b1;
            end
            r_hb_q_ok <= r_hb_ok[i_rd_addr];
            r_em_q_ok <= r_em_ok[i_rd_addr];
        end
    end

    assign o_rd_online = r_hb_q_ok ? r_hb_q[HB_W-1] : 1'b0;
    assign o_rd_nmt    = r_hb_q_ok ? r_hb_q[STATE_W+TIME_W-1:TIME_W] : '0;
    assign o_rd_seen   = r_hb_q_ok ? r_hb_q[TIME_W-1:0] : '0;
    assign o_rd_err    = r_em_q_ok ? r_em_q : '0;

endmodule

>>> rtl/node_heartbeat_monitor_top.sv
// ----------------------------------------------------------------------------
// Node heartbeat monitor
// Liveness tracking for bus nodes: heartbeat, emergency, timeout sweep, query
// and clear, one result per item.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   action, node, nmt, error, time
//   out      source     o_out_valid / i_out_stall online, state, error, counts
//   cfg      sink       i_cfg_we                  heartbeat timeout
//
// Heartbeat, emergency, query and spare actions pass through accept with RAM
// read, read-modify-write and result load. Sweep and clear walk the record
// RAM one node a cycle through its single read port, writing back each node
// they take offline.
// Reset is synchronous and needs no clearing pass: written flags mask the RAMs.
// A stalled result holds in the output register; the next item waits in load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "node_heartbeat_monitor_top_defines.svh"

module node_heartbeat_monitor_top
    import nhm_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TIME_W-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [NODE_W-1:0]  i_node_id,
    input  logic [STATE_W-1:0] i_nmt_state,
    input  logic [ERR_W-1:0]   i_error_register_in,
    input  logic [TIME_W-1:0]  i_now_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_node_online,
    output logic [STATE_W-1:0] o_node_state,
    output logic [ERR_W-1:0]   o_node_error,
    output logic               o_came_online,
    output logic [NODE_W-1:0]  o_dropped_count,
    output logic [NODE_W-1:0]  o_active_nodes,
    output logic [CNT_W-1:0]   o_heartbeats_seen,
    output logic [CNT_W-1:0]   o_emergencies_seen
);

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT);

    t_state r_state, n_state;

    logic [ACT_W-1:0]   r_action;
    logic [NODE_W-1:0]  r_id;
    logic [STATE_W-1:0] r_nmt;
    logic [ERR_W-1:0]   r_err_in;
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_timeout;

    logic                r_tgt_online, n_tgt_online;
    logic [NODE_W-1:0]   r_active, n_active;
    logic [CNT_W-1:0]    r_hb_cnt, n_hb_cnt;
    logic [CNT_W-1:0]    r_em_cnt, n_em_cnt;
    logic                r_came, n_came;
    logic [NODE_W-1:0]   r_dropped, n_dropped;
    logic [STATE_W-1:0]  r_ns, n_ns;
    logic [ERR_W-1:0]    r_ne, n_ne;

    logic [NODE_W-1:0]   r_idx, n_idx;
    logic                r_issue_done, n_issue_done;
    logic                r_chk_valid, n_chk_valid;
    logic [NODE_W-1:0]   r_chk_idx, n_chk_idx;

    logic               r_out_valid;
    logic               r_out_online;
    logic [STATE_W-1:0] r_out_state;
    logic [ERR_W-1:0]   r_out_error;
    logic               r_out_came;
    logic [NODE_W-1:0]  r_out_dropped;
    logic [NODE_W-1:0]  r_out_active;
    logic [CNT_W-1:0]   r_out_hb;
    logic [CNT_W-1:0]   r_out_em;

    logic               w_accept;
    logic               w_load;
    logic               w_valid;
    logic [NODE_W-1:0]  w_rd_addr;
    t_store_wr          w_wr;
    logic               w_rd_online;
    logic [STATE_W-1:0] w_rd_nmt;
    logic [TIME_W-1:0]  w_rd_seen;
    logic [ERR_W-1:0]   w_rd_err;
    logic [TIME_W-1:0]  w_age;
    logic               w_drop;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_valid  = (r_id != '0) && (r_id <= LAST_NODE);
    assign w_age    = r_now - w_rd_seen;
    // a clear drops every online node, a sweep only the stale ones
    assign w_drop   = r_chk_valid && w_rd_online &&
                      ((r_action == ACT_CLEAR) || (w_age > r_timeout));

    nhm_node_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (w_rd_addr),
        .i_wr        (w_wr),
        .o_rd_online (w_rd_online),
        .o_rd_nmt    (w_rd_nmt),
        .o_rd_seen   (w_rd_seen),
        .o_rd_err    (w_rd_err)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if ((r_action == ACT_SWEEP) || (r_action == ACT_CLEAR)) begin
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                if (r_issue_done && !r_chk_valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_load      = 1'b0;
        w_rd_addr   = r_idx;
        w_wr.hb_we  = 1'b0;
        w_wr.em_we  = 1'b0;
        w_wr.addr   = r_id;
        w_wr.online = 1'b1;
        w_wr.nmt    = r_nmt;
        w_wr.seen   = r_now;
        w_wr.err    = r_err_in;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                w_rd_addr  = i_node_id;
            end
            S_READ: begin
                w_wr.hb_we = w_valid && (r_action == ACT_HEARTBEAT);
                w_wr.em_we = w_valid && (r_action == ACT_EMERGENCY);
            end
            S_SWEEP: begin
                w_rd_addr = r_idx;
                // write back the checked node as offline, record kept
                if (w_drop) begin
                    w_wr.hb_we  = 1'b1;
                    w_wr.addr   = r_chk_idx;
                    w_wr.online = 1'b0;
                    w_wr.nmt    = w_rd_nmt;
                    w_wr.seen   = w_rd_seen;
                end
            end
            S_DONE: begin
                w_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // record update and sweep walk
    always_comb begin
        n_tgt_online = r_tgt_online;
        n_active     = r_active;
        n_hb_cnt     = r_hb_cnt;
        n_em_cnt     = r_em_cnt;
        n_came       = r_came;
        n_dropped    = r_dropped;
        n_ns         = r_ns;
        n_ne         = r_ne;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_chk_valid  = 1'b0;
        n_chk_idx    = r_chk_idx;
        case (r_state)
            S_IDLE: begin
                n_came       = 1'b0;
                n_dropped    = '0;
                n_idx        = NODE_W'(1);
                n_issue_done = 1'b0;
            end
            S_READ: begin
                n_tgt_online = w_rd_online;
                n_ns         = w_rd_nmt;
                n_ne         = w_rd_err;
                if (w_valid && (r_action == ACT_HEARTBEAT)) begin
                    n_ns         = r_nmt;
                    n_hb_cnt     = r_hb_cnt + CNT_W'(1);
                    n_tgt_online = 1'b1;
                    if (!w_rd_online) begin
                        n_came   = 1'b1;
                        n_active = r_active + NODE_W'(1);
                    end
                end
                if (w_valid && (r_action == ACT_EMERGENCY)) begin
                    n_ne     = r_err_in;
                    n_em_cnt = r_em_cnt + CNT_W'(1);
                end
            end
            S_SWEEP: begin
                // issue the next read while checking the one before
                if (!r_issue_done) begin
                    n_chk_valid = 1'b1;
                    n_chk_idx   = r_idx;
                    if (r_idx == LAST_NODE) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + NODE_W'(1);
                    end
                end
                if (w_drop) begin
                    n_active = r_active - NODE_W'(1);
                    if (r_action == ACT_SWEEP) begin
                        n_dropped = r_dropped + NODE_W'(1);
                    end
                    if (r_chk_idx == r_id) begin
                        n_tgt_online = 1'b0;
                    end
                end
            end
            default: begin
                n_chk_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_timeout    <= DEFAULT_TIMEOUT;
            r_active     <= '0;
            r_hb_cnt     <= '0;
            r_em_cnt     <= '0;
            r_issue_done <= 1'b0;
            r_chk_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_hb_cnt     <= n_hb_cnt;
            r_em_cnt     <= n_em_cnt;
            r_issue_done <= n_issue_done;
            r_chk_valid  <= n_chk_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_id     <= i_node_id;
            r_nmt    <= i_nmt_state;
            r_err_in <= i_error_register_in;
            r_now    <= i_now_ms;
        end
        r_tgt_online <= n_tgt_online;
        r_came       <= n_came;
        r_dropped    <= n_dropped;
        r_ns         <= n_ns;
        r_ne         <= n_ne;
        r_idx        <= n_idx;
        r_chk_idx    <= n_chk_idx;
        if (w_load) begin
            r_out_online  <= w_valid && r_tgt_online;
            r_out_state   <= w_valid ? r_ns : '0;
            r_out_error   <= w_valid ? r_ne : INVALID_ERROR;
            r_out_came    <= r_came;
            r_out_dropped <= r_dropped;
            r_out_active  <= r_active;
            r_out_hb      <= r_hb_cnt;
            r_out_em      <= r_em_cnt;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_node_online      = r_out_online;
    assign o_node_state       = r_out_state;
    assign o_node_error       = r_out_error;
    assign o_came_online      = r_out_came;
    assign o_dropped_count    = r_out_dropped;
    assign o_active_nodes     = r_out_active;
    assign o_heartbeats_seen  = r_out_hb;
    assign o_emergencies_seen = r_out_em;

    `NHM_ASSERT_NOW(a_active_bound, 1'b1, r_active <= LAST_NODE, "active count too high")
    `NHM_ASSERT_NEXT(a_accept_reads, w_accept, r_state == S_READ, "no read after accept")
    `NHM_ASSERT_NOW(a_load_done, $rose(o_out_valid), $past(r_state) == S_DONE, "bad load")

endmodule
